>>> hw/rtl/qrpr_pkg.sv
// Package for the QR module pixel renderer.
// Holds the transaction structs, the register index codes and the divider chain types.
// No dependencies.
package qrpr_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned CellBits  = 8;
  localparam int unsigned RgbBits   = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned DivW      = 16;  // span is below 2**16 whenever the config is valid
  localparam int unsigned SpanW     = 17;
  localparam int unsigned QuoW      = 8;   // module index across the span stays below 256
  localparam int unsigned QuietMax  = 16;
  localparam int unsigned SizeMin   = 21;

  typedef enum logic [2:0] {
    RegQrSize      = 3'd0,
    RegQuietBorder = 3'd1,
    RegOriginLeft  = 3'd2,
    RegOriginTop   = 3'd3,
    RegPixelScale  = 3'd4,
    RegDarkRgb     = 3'd5,
    RegLightRgb    = 3'd6,
    RegBackRgb     = 3'd7
  } reg_idx_e;

  typedef enum logic {
    FuncLoad   = 1'b0,
    FuncRender = 1'b1
  } func_e;

  typedef struct packed {
    logic                 func;
    logic [CoordBits-1:0] surface_x;
    logic [CoordBits-1:0] pixel_y;
    logic [CellBits-1:0]  cell_x;
    logic [CellBits-1:0]  cell_y;
    logic                 cell_dark;
  } in_t;

  typedef struct packed {
    logic [RgbBits-1:0] pixel_rgb;
    logic               status;
  } out_t;

  // Payload handed from cell to cell along the divider chain.
  typedef struct packed {
    logic            err;
    logic            outside;
    logic [DivW-1:0] rem_x;
    logic [DivW-1:0] rem_y;
    logic [QuoW-1:0] quo_x;
    logic [QuoW-1:0] quo_y;
  } div_t;

endpackage

>>> hw/rtl/qrpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-cycle write. No dependencies.
module qrpr_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 31329
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/qrpr_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit on both axes.
// Depends on qrpr_pkg.
module qrpr_div_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [7:0]         scale_i,
  input  logic               valid_i,
  input  qrpr_pkg::div_t     data_i,
  output logic               valid_o,
  output qrpr_pkg::div_t     data_o
);

  logic [qrpr_pkg::DivW-1:0] trial;
  qrpr_pkg::div_t            data_d, data_q;
  logic                      valid_q;

  always_comb begin
    trial  = qrpr_pkg::DivW'(scale_i) << Shift;
    data_d = data_i;
    if (data_i.rem_x >= trial) begin
      data_d.rem_x        = data_i.rem_x - trial;
      data_d.quo_x[Shift] = 1'b1;
    end
    if (data_i.rem_y >= trial) begin
      data_d.rem_y        = data_i.rem_y - trial;
      data_d.quo_y[Shift] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/qr_module_pixel_renderer.sv
// QR module pixel renderer: bitmap store plus pixel-to-color pipeline.
// A render passes the front stage, the divider cells, the address stage, the bitmap read stage and the output register.
// Throughput: one transaction per cycle while the output is not stalled; load and render transactions mix freely.
// The whole pipeline moves as one; it holds only while the output register is full and stalled.
// Reset clears the registers to 21, 4, 0, 0, 1, 0x0000, 0xFFFF, 0x0000 and empties the pipeline;
// the module bitmap is not cleared and needs no clearing pass.
module qr_module_pixel_renderer #(
  parameter int unsigned MAX_SIDE = 177
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  qrpr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output qrpr_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [qrpr_pkg::CfgBits-1:0]  cfg_wdata_i
);

  localparam int unsigned Depth    = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned Cells    = qrpr_pkg::QuoW;
  localparam int unsigned LdStages = Cells + 2;

  // Configuration registers
  logic [7:0]                     qr_size_q;
  logic [4:0]                     quiet_q;
  logic [qrpr_pkg::CoordBits-1:0] org_x_q, org_y_q;
  logic [7:0]                     scale_q;
  logic [qrpr_pkg::RgbBits-1:0]   dark_q, light_q, back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qr_size_q <= 8'd21;
      quiet_q   <= 5'd4;
      org_x_q   <= '0;
      org_y_q   <= '0;
      scale_q   <= 8'd1;
      dark_q    <= 16'h0000;
      light_q   <= 16'hFFFF;
      back_q    <= 16'h0000;
    end else if (cfg_we_i) begin
      unique case (qrpr_pkg::reg_idx_e'(cfg_idx_i))
        qrpr_pkg::RegQrSize:      qr_size_q <= cfg_wdata_i[7:0];
        qrpr_pkg::RegQuietBorder: quiet_q   <= cfg_wdata_i[4:0];
        qrpr_pkg::RegOriginLeft:  org_x_q   <= cfg_wdata_i[qrpr_pkg::CoordBits-1:0];
        qrpr_pkg::RegOriginTop:   org_y_q   <= cfg_wdata_i[qrpr_pkg::CoordBits-1:0];
        qrpr_pkg::RegPixelScale:  scale_q   <= cfg_wdata_i[7:0];
        qrpr_pkg::RegDarkRgb:     dark_q    <= cfg_wdata_i;
        qrpr_pkg::RegLightRgb:    light_q   <= cfg_wdata_i;
        qrpr_pkg::RegBackRgb:     back_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: move everything unless the output register is full and stalled.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // Load path: carry the module bit down to the read stage and write it there, so that
  // bitmap reads and writes happen in transaction order.
  logic             ld_we;
  logic [AddrW-1:0] ld_addr;
  assign ld_we   = accept && (in_data_i.func == qrpr_pkg::FuncLoad)
                && (32'(in_data_i.cell_x) < MAX_SIDE) && (32'(in_data_i.cell_y) < MAX_SIDE);
  assign ld_addr = AddrW'(AddrW'(in_data_i.cell_y) * AddrW'(MAX_SIDE))
                 + AddrW'(in_data_i.cell_x);

  logic [LdStages-1:0] ld_v_q;
  logic [AddrW-1:0]    ld_addr_q [LdStages];
  logic                ld_dark_q [LdStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_v_q <= '0;
    end else if (adv) begin
      ld_v_q <= {ld_v_q[LdStages-2:0], ld_we};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld_addr_q[0] <= ld_addr;
      ld_dark_q[0] <= in_data_i.cell_dark;
      for (int i = 1; i < LdStages; i++) begin
        ld_addr_q[i] <= ld_addr_q[i-1];
        ld_dark_q[i] <= ld_dark_q[i-1];
      end
    end
  end

  // Front stage: config check, origin subtract, span compare.
  logic                          cfg_ok;
  logic [8:0]                    total;
  logic [qrpr_pkg::SpanW-1:0]    span;
  logic [qrpr_pkg::CoordBits:0]  dx, dy;
  logic                          in_x, in_y;
  qrpr_pkg::div_t                front_d, front_q;
  logic                          front_v_q;

  always_comb begin
    cfg_ok = (32'(qr_size_q) >= qrpr_pkg::SizeMin) && (32'(qr_size_q) <= MAX_SIDE)
          && (qr_size_q[1:0] == 2'b01) && (scale_q != 8'd0)
          && (32'(quiet_q) <= qrpr_pkg::QuietMax);
    total  = 9'(qr_size_q) + 9'({quiet_q, 1'b0});
    span   = qrpr_pkg::SpanW'(total) * qrpr_pkg::SpanW'(scale_q);
    dx     = {1'b0, in_data_i.surface_x} - {1'b0, org_x_q};
    dy     = {1'b0, in_data_i.pixel_y} - {1'b0, org_y_q};
    in_x   = !dx[qrpr_pkg::CoordBits]
          && (qrpr_pkg::SpanW'(dx[qrpr_pkg::CoordBits-1:0]) < span);
    in_y   = !dy[qrpr_pkg::CoordBits]
          && (qrpr_pkg::SpanW'(dy[qrpr_pkg::CoordBits-1:0]) < span);
    front_d.err     = !cfg_ok;
    front_d.outside = !(in_x && in_y);
    front_d.rem_x   = qrpr_pkg::DivW'(dx[qrpr_pkg::CoordBits-1:0]);
    front_d.rem_y   = qrpr_pkg::DivW'(dy[qrpr_pkg::CoordBits-1:0]);
    front_d.quo_x   = '0;
    front_d.quo_y   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (adv) begin
      // Load transactions leave a bubble; they produce no result.
      front_v_q <= in_valid_i && (in_data_i.func == qrpr_pkg::FuncRender);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q <= front_d;
    end
  end

  // Divider chain: each cell resolves one quotient bit, most significant first.
  qrpr_pkg::div_t   chain [Cells+1];
  logic [Cells:0]   chain_v;

  assign chain[0]   = front_q;
  assign chain_v[0] = front_v_q;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    qrpr_div_cell #(
      .Shift(Cells - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .scale_i (scale_q),
      .valid_i (chain_v[g]),
      .data_i  (chain[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain[g+1])
    );
  end

  // Address stage: drop the quiet border, check code range, form the bitmap address.
  qrpr_pkg::div_t   tail;
  logic [8:0]       qx, qy;
  logic             code_d;
  logic [AddrW-1:0] addr_d;
  logic             b_v_q, b_err_q, b_out_q, b_code_q;
  logic [AddrW-1:0] b_addr_q;

  assign tail = chain[Cells];

  always_comb begin
    qx     = {1'b0, tail.quo_x} - 9'(quiet_q);
    qy     = {1'b0, tail.quo_y} - 9'(quiet_q);
    code_d = !qx[8] && !qy[8] && (qx[7:0] < qr_size_q) && (qy[7:0] < qr_size_q);
    addr_d = '0;
    if (code_d) begin
      addr_d = AddrW'(AddrW'(qy[7:0]) * AddrW'(MAX_SIDE)) + AddrW'(qx[7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv) begin
      b_v_q <= chain_v[Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_err_q  <= tail.err;
      b_out_q  <= tail.outside;
      b_code_q <= code_d;
      b_addr_q <= addr_d;
    end
  end

  // Bitmap read stage: read data arrives alongside the flags. A delayed load write
  // lands at the same stage, so it never overtakes or trails a render.
  logic c_v_q, c_err_q, c_out_q, c_code_q;
  logic rd_dark;

  qrpr_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (adv && ld_v_q[LdStages-1]),
    .waddr_i (ld_addr_q[LdStages-1]),
    .wdata_i (ld_dark_q[LdStages-1]),
    .re_i    (adv),
    .raddr_i (b_addr_q),
    .rdata_o (rd_dark)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_err_q  <= b_err_q;
      c_out_q  <= b_out_q;
      c_code_q <= b_code_q;
    end
  end

  // Color select into the output register.
  qrpr_pkg::out_t out_d, out_q;

  always_comb begin
    out_d.status = c_err_q;
    if (c_err_q) begin
      out_d.pixel_rgb = '0;
    end else if (c_out_q) begin
      out_d.pixel_rgb = back_q;
    end else if (c_code_q && rd_dark) begin
      out_d.pixel_rgb = dark_q;
    end else begin
      out_d.pixel_rgb = light_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/qrpr_checker.sv
// Port-level checker for the QR module pixel renderer, bound to the top level.
// Depends on qrpr_pkg and qr_module_pixel_renderer.
module qrpr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input qrpr_pkg::out_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Error results carry a zero color.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.pixel_rgb == '0)
    else $error("error result with nonzero color");

  // Input stalls only behind a full, stalled output register.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind qr_module_pixel_renderer qrpr_checker u_qrpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_top.sv
// Testbench for the QR module pixel renderer: drives load and render transactions,
// predicts every color and status, and checks the results in order.
// Depends on qrpr_pkg and qr_module_pixel_renderer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side = 177;

  // Holds the register copy, the module bitmap and the queue of expected pixels.
  class pixel_scoreboard;
    int unsigned    regs[8];
    bit             cell_val[Side*Side];
    bit             cell_set[Side*Side];
    qrpr_pkg::out_t pixel_q[$];
    int             errors;

    function new();
      regs = '{21, 4, 0, 0, 1, 16'h0000, 16'hFFFF, 16'h0000};
      errors = 0;
    endfunction

    function void set_reg(int idx, int unsigned val);
      case (idx)
        qrpr_pkg::RegQrSize:      regs[idx] = val & 8'hFF;
        qrpr_pkg::RegQuietBorder: regs[idx] = val & 5'h1F;
        qrpr_pkg::RegOriginLeft,
        qrpr_pkg::RegOriginTop:   regs[idx] = val & 12'hFFF;
        qrpr_pkg::RegPixelScale:  regs[idx] = val & 8'hFF;
        default:                  regs[idx] = val & 16'hFFFF;
      endcase
    endfunction

    function bit cfg_ok();
      int unsigned s;
      s = regs[qrpr_pkg::RegQrSize];
      if (s < 21 || s > Side || ((s - 17) % 4) != 0) return 0;
      if (regs[qrpr_pkg::RegPixelScale] == 0 || regs[qrpr_pkg::RegQuietBorder] > 16) return 0;
      return 1;
    endfunction

    function int unsigned span_px();
      return (regs[qrpr_pkg::RegQrSize] + 2 * regs[qrpr_pkg::RegQuietBorder])
             * regs[qrpr_pkg::RegPixelScale];
    endfunction

    // Module index along one axis, -1 outside the drawn span.
    function int axis_module(int pos, int org);
      int lp;
      lp = pos - org;
      if (lp < 0 || lp >= int'(span_px())) return -1;
      return lp / int'(regs[qrpr_pkg::RegPixelScale]);
    endfunction

    // Code cell a render reads, or -1 when it reads none.
    function int cell_read(int sx, int sy);
      int mx, my, qx, qy;
      if (!cfg_ok()) return -1;
      mx = axis_module(sx, regs[qrpr_pkg::RegOriginLeft]);
      my = axis_module(sy, regs[qrpr_pkg::RegOriginTop]);
      if (mx < 0 || my < 0) return -1;
      qx = mx - int'(regs[qrpr_pkg::RegQuietBorder]);
      qy = my - int'(regs[qrpr_pkg::RegQuietBorder]);
      if (qx < 0 || qy < 0 || qx >= int'(regs[qrpr_pkg::RegQrSize])
          || qy >= int'(regs[qrpr_pkg::RegQrSize]))
        return -1;
      return qy * Side + qx;
    endfunction

    function void note_input(qrpr_pkg::in_t d);
      qrpr_pkg::out_t e;
      int             c;
      if (d.func == qrpr_pkg::FuncLoad) begin
        if (d.cell_x < Side && d.cell_y < Side) begin
          cell_val[d.cell_y * Side + d.cell_x] = d.cell_dark;
          cell_set[d.cell_y * Side + d.cell_x] = 1;
        end
        return;
      end
      e = '0;
      if (!cfg_ok()) begin
        e.status = 1'b1;
      end else if (axis_module(d.surface_x, regs[qrpr_pkg::RegOriginLeft]) < 0 ||
                   axis_module(d.pixel_y, regs[qrpr_pkg::RegOriginTop]) < 0) begin
        e.pixel_rgb = 16'(regs[qrpr_pkg::RegBackRgb]);
      end else begin
        c = cell_read(d.surface_x, d.pixel_y);
        e.pixel_rgb = (c >= 0 && cell_val[c]) ? 16'(regs[qrpr_pkg::RegDarkRgb])
                                              : 16'(regs[qrpr_pkg::RegLightRgb]);
      end
      pixel_q.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(qrpr_pkg::out_t got);
      qrpr_pkg::out_t e;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
        return;
      end
      e = pixel_q.pop_front();
      if (got.pixel_rgb !== e.pixel_rgb)
        report($sformatf("pixel_rgb got %h want %h", got.pixel_rgb, e.pixel_rgb));
      if (got.status !== e.status)
        report($sformatf("status got %b want %b", got.status, e.status));
    endtask
  endclass

  logic                         clk_i = 0;
  logic                         rst_ni = 0;
  logic                         in_valid_i = 0;
  logic                         in_ready_o;
  qrpr_pkg::in_t                in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 0;
  qrpr_pkg::out_t               out_data_o;
  logic                         cfg_we_i = 0;
  logic [2:0]                   cfg_idx_i = '0;
  logic [qrpr_pkg::CfgBits-1:0] cfg_wdata_i = '0;

  pixel_scoreboard sb = new();
  int  send_max = 19;
  int  recv_max = 19;
  bit  hold_req = 0;
  bit  first_item = 1;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  qr_module_pixel_renderer dut (.*);

  // Offer one transaction after a random gap; hold it until accepted.
  task send(qrpr_pkg::in_t d);
    int gap;
    gap = $urandom_range(0, send_max);
    if (gap > 0 || first_item) begin
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    first_item = 0;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(d);
  endtask

  task load_cell(int cx, int cy, bit dark);
    qrpr_pkg::in_t d;
    d = '0;
    d.func = qrpr_pkg::FuncLoad;
    d.cell_x = 8'(cx);
    d.cell_y = 8'(cy);
    d.cell_dark = dark;
    d.surface_x = 12'($urandom);
    d.pixel_y = 12'($urandom);
    send(d);
  endtask

  // Render one pixel; first load the code cell it reads if that cell is still unknown.
  task render(int sx, int sy);
    qrpr_pkg::in_t d;
    int            c;
    c = sb.cell_read(sx, sy);
    if (c >= 0 && !sb.cell_set[c]) load_cell(c % Side, c / Side, $urandom_range(0, 1));
    d = '0;
    d.func = qrpr_pkg::FuncRender;
    d.surface_x = 12'(sx);
    d.pixel_y = 12'(sy);
    d.cell_x = 8'($urandom);
    d.cell_y = 8'($urandom);
    d.cell_dark = 1'($urandom);
    send(d);
  endtask

  // Stop offering transactions and drain the block.
  task wait_idle();
    in_valid_i <= 1'b0;
    first_item = 1;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task write_reg(qrpr_pkg::reg_idx_e idx, int unsigned val);
    logic [qrpr_pkg::CfgBits-1:0] w;
    w = qrpr_pkg::CfgBits'(val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, w);
  endtask

  task set_config(int sz, int qb, int ol, int ot, int sc);
    wait_idle();
    // Upper data bits beyond each register's width are junk and must be dropped.
    write_reg(qrpr_pkg::RegQrSize,      sz | ($urandom & 16'hFF00));
    write_reg(qrpr_pkg::RegQuietBorder, qb | ($urandom & 16'hFFE0));
    write_reg(qrpr_pkg::RegOriginLeft,  ol | ($urandom & 16'hF000));
    write_reg(qrpr_pkg::RegOriginTop,   ot | ($urandom & 16'hF000));
    write_reg(qrpr_pkg::RegPixelScale,  sc | ($urandom & 16'hFF00));
    write_reg(qrpr_pkg::RegDarkRgb,     $urandom);
    write_reg(qrpr_pkg::RegLightRgb,    $urandom);
    write_reg(qrpr_pkg::RegBackRgb,     $urandom);
  endtask

  function int near(int org);
    int p;
    p = org + int'($urandom_range(0, sb.span_px() + 3)) - 2;
    if (p < 0 || p > 4095) p = $urandom_range(0, 4095);
    return p;
  endfunction

  task run_phase(int n);
    int sz;
    send_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
    recv_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          sz = (sb.regs[qrpr_pkg::RegQrSize] > 0 && sb.regs[qrpr_pkg::RegQrSize] <= Side)
               ? sb.regs[qrpr_pkg::RegQrSize] : Side;
          if ($urandom_range(0, 5) == 0)
            load_cell($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
          else
            load_cell($urandom_range(0, sz - 1), $urandom_range(0, sz - 1), $urandom_range(0, 1));
        end
        2:       render($urandom_range(0, 4095), $urandom_range(0, 4095));
        default: render(near(sb.regs[qrpr_pkg::RegOriginLeft]),
                        near(sb.regs[qrpr_pkg::RegOriginTop]));
      endcase
    end
  endtask

  // Receiver: random ready gaps, one long hold-off when asked.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, recv_max);
      if (hold_req) begin
        gap = 300;
        hold_req = 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check(out_data_o);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, span of 29 pixels, code at modules 4..24.
    load_cell(0, 0, 1);
    load_cell(Side, 0, 0);       // out of range, ignored
    load_cell(0, Side, 0);
    load_cell(255, 255, 0);
    render(4, 4);                // dark module at the code corner
    render(0, 0);                // quiet zone
    render(28, 28);              // last pixel of the span
    render(29, 0);               // just past the span
    render(0, 29);
    render(4095, 4095);
    render(24, 24);
    render(5, 4);
    load_cell(0, 0, 0);
    render(4, 4);
    // Origin above the pixel: coordinates below the origin.
    set_config(21, 0, 100, 100, 2);
    render(99, 150);
    render(150, 99);
    render(100, 100);
    render(141, 141);
    render(142, 100);
    // Invalid settings return the error status.
    set_config(0, 4, 0, 0, 1);
    render(0, 0);
    set_config(21, 4, 0, 0, 0);
    render(0, 0);
    set_config(21, 17, 0, 0, 1);
    render(0, 0);

    // Random: several settings, extremes among them.
    set_config(177, 16, 0, 0, 1);
    hold_req = 1;                 // long receiver stall while items keep coming
    run_phase(150);
    set_config(21, 0, 4095, 4095, 1);   run_phase(60);
    set_config(25, 3, 4000, 3990, 3);   run_phase(120);
    set_config(177, 16, 0, 0, 255);     run_phase(80);
    set_config(22, 4, 0, 0, 1);         run_phase(40);
    set_config(255, 4, 0, 0, 1);        run_phase(40);
    set_config(33, 31, 0, 0, 2);        run_phase(40);
    set_config(181, 2, 10, 10, 1);      run_phase(40);
    set_config(21, 16, 0, 0, 7);        run_phase(120);
    for (int k = 0; k < 6; k++) begin
      set_config(21 + 4 * $urandom_range(0, 39), $urandom_range(0, 16),
                 $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 9));
      run_phase(120);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(8 * 2000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> qr_module_pixel_renderer.f
hw/rtl/qrpr_pkg.sv
hw/rtl/qrpr_ram.sv
hw/rtl/qrpr_div_cell.sv
hw/rtl/qr_module_pixel_renderer.sv
hw/rtl/qrpr_checker.sv
tb/tb_top.sv
